/* rtl/spi_baud_divider_search_assert.svh */
// Assertion macros used by the checker file.
`ifndef SPI_BAUD_DIVIDER_SEARCH_ASSERT_SVH
`define SPI_BAUD_DIVIDER_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SBDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define SBDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbds_pkg.sv */
package sbds_pkg;

  localparam logic [31:0] CLK_HZ_RESET    = 32'd48000000;
  localparam logic [1:0]  DEFAULT_PRE     = 2'd3;
  localparam logic [3:0]  DEFAULT_SCL     = 4'd7;
  localparam logic [30:0] WORST_GAP       = 31'h7FFF_FFFF;
  localparam int          CLK_W           = 32;
  localparam int          TARGET_W        = 31;
  localparam int          DIVISOR_W       = 18;

  // Prescaler values 2, 3, 5 and 7.
  function automatic logic [2:0] pre_val(input logic [1:0] idx);
    logic [2:0] v;
    case (idx)
      2'd0:    v = 3'd2;
      2'd1:    v = 3'd3;
      2'd2:    v = 3'd5;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

  // Scaler values 2, 4, 6, 8, then 2^idx from index 4 up to 32768.
  function automatic logic [15:0] scl_val(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:    v = 16'd2;
      4'd1:    v = 16'd4;
      4'd2:    v = 16'd6;
      4'd3:    v = 16'd8;
      default: v = 16'd1 << idx;
    endcase
    return v;
  endfunction

  // Combined divisor; the largest product, 7 * 32768, fits in 18 bits.
  function automatic logic [DIVISOR_W-1:0] divisor_of(input logic [1:0] p,
                                                      input logic [3:0] s);
    logic [18:0] prod;
    prod = 19'(pre_val(p)) * 19'(scl_val(s));
    return prod[DIVISOR_W-1:0];
  endfunction

endpackage

/* rtl/sbds_ifs.sv */
// Request channel: one target bit rate per transfer.
interface sbds_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

// Result channel: the chosen divider settings per transfer.
interface sbds_out_if;
  logic       valid;
  logic       ready;
  logic       double_rate;
  logic [1:0] prescale_select;
  logic [3:0] scale_select;

  modport source (output valid, output double_rate, output prescale_select,
                  output scale_select, input ready);
  modport sink   (input valid, input double_rate, input prescale_select,
                  input scale_select, output ready);
endinterface

/* rtl/spi_baud_divider_search.sv */
// A request goes from ST_IDLE to ST_CHECK, then to ST_DONE if double-rate mode applies.
// Otherwise up to 64 candidate dividers are tried, each through ST_LOAD, the bit-serial
// divider in ST_DIV and the compare states ST_EVAL and ST_CMP; ST_DONE then offers
// the result once the output register is free.
// A new request is taken once the last has left ST_DONE, even while its result waits.
// Reset (rst, synchronous) empties the block and sets clock_hz to 48000000.
module spi_baud_divider_search import sbds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  sbds_in_if.sink     req,
  sbds_out_if.source  rsp
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [CLK_W-1:0]     clock_hz;
  logic [2:0]           state;
  logic [TARGET_W-1:0]  target;
  logic [1:0]           pre_idx;
  logic [3:0]           scl_idx;
  logic [1:0]           best_pre;
  logic [3:0]           best_scl;
  logic [TARGET_W-1:0]  best_gap;
  logic                 dbl;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem;
  logic [CLK_W-1:0]     quo;
  logic [4:0]           step_cnt;
  logic [TARGET_W-1:0]  gap;
  logic                 gap_neg;
  logic                 out_valid;
  logic                 out_dbl;
  logic [1:0]           out_pre;
  logic [3:0]           out_scl;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W+1:0] trial;
  logic                 fits;
  logic [DIVISOR_W-1:0] rem_next;
  logic [CLK_W:0]       diff;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  // One restoring division step: bring in the next dividend bit and try the divisor.
  always_comb begin
    shifted  = {rem, quo[CLK_W-1]};
    trial    = {1'b0, shifted} - {2'b00, divisor};
    fits     = !trial[DIVISOR_W+1];
    rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  // Signed gap between target and candidate rate; the top bit marks a rate above target.
  assign diff = {2'b00, target} - {1'b0, quo};

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one replaces it now.
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            target <= req.target_hz;
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          dbl      <= ({1'b0, clock_hz} <= {1'b0, target, 1'b0});
          pre_idx  <= 2'd3;
          scl_idx  <= 4'd15;
          best_pre <= DEFAULT_PRE;
          best_scl <= DEFAULT_SCL;
          best_gap <= WORST_GAP;
          if ({1'b0, clock_hz} <= {1'b0, target, 1'b0}) begin
            state <= ST_DONE;
          end else begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          divisor  <= divisor_of(pre_idx, scl_idx);
          rem      <= '0;
          quo      <= clock_hz;
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          rem      <= rem_next;
          quo      <= {quo[CLK_W-2:0], fits};
          step_cnt <= step_cnt + 5'd1;
          if (step_cnt == 5'd31) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          gap     <= diff[TARGET_W-1:0];
          gap_neg <= diff[CLK_W];
          state   <= ST_CMP;
        end
        ST_CMP: begin
          if (!gap_neg && gap < best_gap) begin
            best_gap <= gap;
            best_pre <= pre_idx;
            best_scl <= scl_idx;
          end
          // A rate above target, or the last scaler, ends this prescaler's walk.
          if (gap_neg || scl_idx == 4'd0) begin
            if (pre_idx == 2'd0) begin
              state <= ST_DONE;
            end else begin
              pre_idx <= pre_idx - 2'd1;
              scl_idx <= 4'd15;
              state   <= ST_LOAD;
            end
          end else begin
            scl_idx <= scl_idx - 4'd1;
            state   <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_dbl   <= dbl;
            out_pre   <= dbl ? 2'd0 : best_pre;
            out_scl   <= dbl ? 4'd0 : best_scl;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready           = (state == ST_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.double_rate     = out_dbl;
  assign rsp.prescale_select = out_pre;
  assign rsp.scale_select    = out_scl;

endmodule

/* rtl/sbds_checker.sv */
`include "spi_baud_divider_search_assert.svh"

// Port-level checks on the divider search block.
module sbds_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_double_rate,
  input logic [1:0] rsp_prescale_select,
  input logic [3:0] rsp_scale_select
);

  logic [5:0] rsp_sel;
  logic [6:0] rsp_payload;

  // Result fields gathered for the checks below.
  assign rsp_sel     = {rsp_prescale_select, rsp_scale_select};
  assign rsp_payload = {rsp_double_rate, rsp_sel};

  // A stalled result stays offered.
  `SBDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

  // A stalled result keeps its settings.
  `SBDS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload), "result changed")

  // Double-rate mode always comes with both selectors zero.
  `SBDS_ASSERT_NOW(a_dbl_zero, rsp_valid && rsp_double_rate, rsp_sel == 6'd0, "selector set")

  // After a request transfer the block is busy and takes no second request.
  `SBDS_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind spi_baud_divider_search sbds_checker u_sbds_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_double_rate     (rsp.double_rate),
  .rsp_prescale_select (rsp.prescale_select),
  .rsp_scale_select    (rsp.scale_select)
);
